// ----- src/rbsi_pkg.sv -----
`default_nettype none
package rbsi_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  // prep register, divider pipeline (DW + 1), lane result register
  localparam int LAT = DW + 3;
  localparam int NUM_AXES = 3;
  localparam int IN_W = 2 * NUM_AXES * DW;
  localparam int OUT_W = ((2 * DW + 1 + 7) / 8) * 8;
  localparam int CFG_AW = 3;

  typedef logic signed [DW-1:0] val_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_e;

  typedef struct packed {
    logic signed [DW-1:0] tn;
    logic signed [DW-1:0] tf;
    logic                 miss;
  } lane_res_t;

  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

endpackage
`default_nettype wire

// ----- src/ray_box_slab_intersect_top.sv -----
`default_nettype none
// ray against axis-aligned box, slab method, signed Q16.16. three axis lanes
// run side by side, each with two pipelined restoring dividers that give one
// quotient bit per stage; a merge stage takes the largest entry and the
// smallest exit and decides the hit. one ray beat is taken every cycle while
// not stalled; it passes the prep register, 33 divider stages, lane result
// register and output register. the whole pipe stalls only while a finished
// result waits on m_axis_tready. box corners are written through the cfg
// port; the user must do so only while the block is idle (not enforced).
module ray_box_slab_intersect_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write port, index follows rbsi_pkg::reg_e
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [rbsi_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  wire logic [rbsi_pkg::DW-1:0]       cfg_data_i,
  // ray beats
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  wire logic [rbsi_pkg::IN_W-1:0]     s_axis_tdata,
  // result beats
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // hit, near_dist, far_dist, zero pad
  output logic [rbsi_pkg::OUT_W-1:0]         m_axis_tdata
);
  localparam int W = rbsi_pkg::DW;
  localparam int LAT = rbsi_pkg::LAT;

  rbsi_pkg::val_t box_min_q [0:2];
  rbsi_pkg::val_t box_max_q [0:2];

  // corner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
    end else if (cfg_wr_en_i) begin
      case (rbsi_pkg::reg_e'(cfg_addr_i))
        rbsi_pkg::REG_MIN_X: box_min_q[0] <= cfg_data_i;
        rbsi_pkg::REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        rbsi_pkg::REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        rbsi_pkg::REG_MAX_X: box_max_q[0] <= cfg_data_i;
        rbsi_pkg::REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        rbsi_pkg::REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipe advances unless the output register holds a beat nobody takes
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  rbsi_pkg::lane_res_t res [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    rbsi_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .org_i (s_axis_tdata[a*W +: W]),
      .dir_i (s_axis_tdata[(a+3)*W +: W]),
      .c0_i  (box_min_q[a]),
      .c1_i  (box_max_q[a]),
      .res_o (res[a])
    );
  end

  logic           hit;
  rbsi_pkg::val_t near_dist, far_dist;

  rbsi_merge u_merge (
    .res_x_i (res[0]),
    .res_y_i (res[1]),
    .res_z_i (res[2]),
    .hit_o   (hit),
    .near_o  (near_dist),
    .far_o   (far_dist)
  );

  // output register
  logic                        out_vld_q;
  logic [rbsi_pkg::OUT_W-1:0]  out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_data_q <= rbsi_pkg::OUT_W'({far_dist, near_dist, hit});
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire

// ----- src/rbsi_div.sv -----
`default_nettype none
module rbsi_div (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [rbsi_pkg::DW:0]  mag_i,
  input  wire logic [rbsi_pkg::DW-1:0] dmag_i,
  input  wire logic                   neg_i,
  output rbsi_pkg::val_t              quot_o
);
  localparam int W = rbsi_pkg::DW;
  localparam int FB = rbsi_pkg::FB;

  logic [W+FB:0] num;
  logic [FB:0]   num_hi;
  logic [W:0]    rem_q  [0:W];
  logic [W-1:0]  low_q  [0:W];
  logic [W-1:0]  quo_q  [0:W];
  logic [W-1:0]  dmag_q [0:W];
  logic          neg_q  [0:W];
  logic          over_q [0:W];

  assign num    = {mag_i, {FB{1'b0}}};
  assign num_hi = num[W+FB:W];

  // quotient of 2^W or more cannot fit, flag it up front
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= (W+1)'(num_hi);
      low_q[0]  <= num[W-1:0];
      quo_q[0]  <= '0;
      dmag_q[0] <= dmag_i;
      neg_q[0]  <= neg_i;
      over_q[0] <= (W+1)'(num_hi) >= {1'b0, dmag_i};
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0] trial;
    logic       ge;
    assign trial = {rem_q[k][W-1:0], low_q[k][W-1]};
    assign ge    = trial >= {1'b0, dmag_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? trial - {1'b0, dmag_q[k]} : trial;
        low_q[k+1]  <= {low_q[k][W-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][W-2:0], ge};
        dmag_q[k+1] <= dmag_q[k];
        neg_q[k+1]  <= neg_q[k];
        over_q[k+1] <= over_q[k];
      end
    end
  end

  logic [W-1:0] half;
  assign half = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    if (neg_q[W]) begin
      if (over_q[W] || quo_q[W] > half) quot_o = rbsi_pkg::VAL_MIN;
      else quot_o = -$signed(quo_q[W]);
    end else begin
      if (over_q[W] || quo_q[W][W-1]) quot_o = rbsi_pkg::VAL_MAX;
      else quot_o = $signed(quo_q[W]);
    end
  end
endmodule
`default_nettype wire

// ----- src/rbsi_lane.sv -----
`default_nettype none
module rbsi_lane (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire rbsi_pkg::val_t org_i,
  input  wire rbsi_pkg::val_t dir_i,
  input  wire rbsi_pkg::val_t c0_i,
  input  wire rbsi_pkg::val_t c1_i,
  output rbsi_pkg::lane_res_t res_o
);
  localparam int W = rbsi_pkg::DW;

  logic signed [W:0] diff0_q, diff1_q;
  logic [W-1:0]      dmag_q;
  logic              dneg_q;
  logic [1:0]        flg_q [0:W+1];   // {zero dir, origin inside slab}

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff0_q  <= (W+1)'(c0_i) - (W+1)'(org_i);
      diff1_q  <= (W+1)'(c1_i) - (W+1)'(org_i);
      dneg_q   <= dir_i[W-1];
      dmag_q   <= dir_i[W-1] ? W'(-dir_i) : W'(dir_i);
      flg_q[0] <= {dir_i == '0,
                   (org_i >= c0_i && org_i <= c1_i) || (org_i >= c1_i && org_i <= c0_i)};
    end
  end

  for (genvar k = 0; k <= W; k++) begin : g_flg
    always_ff @(posedge clk_i) begin
      if (en_i) flg_q[k+1] <= flg_q[k];
    end
  end

  logic [W:0] mag0, mag1;
  assign mag0 = diff0_q[W] ? (W+1)'(-diff0_q) : (W+1)'(diff0_q);
  assign mag1 = diff1_q[W] ? (W+1)'(-diff1_q) : (W+1)'(diff1_q);

  rbsi_pkg::val_t t0, t1;

  rbsi_div u_div0 (
    .clk_i (clk_i), .en_i (en_i), .mag_i (mag0), .dmag_i (dmag_q),
    .neg_i (diff0_q[W] ^ dneg_q), .quot_o (t0)
  );
  rbsi_div u_div1 (
    .clk_i (clk_i), .en_i (en_i), .mag_i (mag1), .dmag_i (dmag_q),
    .neg_i (diff1_q[W] ^ dneg_q), .quot_o (t1)
  );

  rbsi_pkg::lane_res_t res_d, res_q;

  always_comb begin
    if (flg_q[W+1][1]) begin
      res_d.tn   = rbsi_pkg::VAL_MIN;
      res_d.tf   = rbsi_pkg::VAL_MAX;
      res_d.miss = !flg_q[W+1][0];
    end else begin
      res_d.tn   = (t0 < t1) ? t0 : t1;
      res_d.tf   = (t0 < t1) ? t1 : t0;
      res_d.miss = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

// ----- src/rbsi_merge.sv -----
`default_nettype none
module rbsi_merge (
  input  wire rbsi_pkg::lane_res_t res_x_i,
  input  wire rbsi_pkg::lane_res_t res_y_i,
  input  wire rbsi_pkg::lane_res_t res_z_i,
  output logic                     hit_o,
  output rbsi_pkg::val_t           near_o,
  output rbsi_pkg::val_t           far_o
);
  rbsi_pkg::val_t near_xy, far_xy, near_all, far_all;

  assign near_xy  = (res_y_i.tn > res_x_i.tn) ? res_y_i.tn : res_x_i.tn;
  assign near_all = (res_z_i.tn > near_xy) ? res_z_i.tn : near_xy;
  assign far_xy   = (res_y_i.tf < res_x_i.tf) ? res_y_i.tf : res_x_i.tf;
  assign far_all  = (res_z_i.tf < far_xy) ? res_z_i.tf : far_xy;

  assign hit_o  = !(res_x_i.miss || res_y_i.miss || res_z_i.miss) &&
                  !far_all[rbsi_pkg::DW-1] && far_all >= near_all;
  assign near_o = hit_o ? near_all : '0;
  assign far_o  = hit_o ? far_all : '0;
endmodule
`default_nettype wire
